FILE: sv/rmr_pkg.sv
// ----------------------------------------------------------------------------
// rmr_pkg
// Types, codes and the message type classifier shared by the reassembler.
// ----------------------------------------------------------------------------
package rmr_pkg;

  // item codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_BYTE  = 2'd0,
    MODE_ABORT = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // message type categories
  typedef enum logic [2:0] {
    CAT_CONTROL = 3'd0,
    CAT_AUDIO   = 3'd1,
    CAT_VIDEO   = 3'd2,
    CAT_DATA    = 3'd3,
    CAT_COMMAND = 3'd4,
    CAT_SHARED  = 3'd5,
    CAT_AGGR    = 3'd6,
    CAT_UNKNOWN = 3'd7
  } category_e;

  localparam int unsigned LenW   = 24;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned PendW  = 7;
  localparam logic [LenW-1:0] LenMax = '1;

  typedef struct packed {
    logic [1:0]      mode;
    logic [SlotW-1:0] stream_slot;
    logic [LenW-1:0] msg_length;
    logic [31:0]     stamp_in;
    logic [7:0]      type_id;
    logic [31:0]     msg_stream_in;
    logic            has_byte;
    logic [7:0]      data_byte;
    logic            chunk_end;
    logic            chunk_done;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0] out_slot;
    logic [7:0]      out_byte;
    logic            out_has_byte;
    logic            msg_first;
    logic            msg_last;
    logic [7:0]      out_type;
    logic [2:0]      category;
    logic            known_type;
    logic [31:0]     out_stamp;
    logic [31:0]     out_msg_stream;
    logic [LenW-1:0] out_length;
    logic [PendW-1:0] pending_count;
  } out_item_t;

  // per-slot message context kept in the context memory
  typedef struct packed {
    logic [LenW-1:0] exp_len;
    logic [LenW-1:0] rcv_count;
    logic [31:0]     stamp;
    logic [7:0]      msg_type;
    logic [31:0]     msg_id;
  } ctx_t;

  function automatic category_e type_category(input logic [7:0] t);
    category_e c;
    c = CAT_UNKNOWN;
    case (t)
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6: c = CAT_CONTROL;
      8'd8:          c = CAT_AUDIO;
      8'd9:          c = CAT_VIDEO;
      8'd15, 8'd18:  c = CAT_DATA;
      8'd17, 8'd20:  c = CAT_COMMAND;
      8'd16, 8'd19:  c = CAT_SHARED;
      8'd22:         c = CAT_AGGR;
      default:       c = CAT_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/rmr_ram.sv
// ----------------------------------------------------------------------------
// rmr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rtmp_message_reassembler.sv
// ----------------------------------------------------------------------------
// rtmp_message_reassembler
// Per chunk stream message reassembly: latches the header on the first item
// of a message, counts payload bytes and marks message boundaries.
// ----------------------------------------------------------------------------
// an accepted item is registered in the input stage (s1_q), then its result
//   in the result register (out_q) once that register is free
// throughput: one item per cycle while out_ready_i does not stall the output,
//   kept by the context read-modify-write (registered memory read, one-deep write bypass)
// reset: started flags, open count and both pipeline valids clear at once;
//   the context memory is not cleared, a slot writes it when it starts
module rtmp_message_reassembler #(
  parameter int unsigned STREAM_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmr_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(STREAM_SLOTS);
  localparam int unsigned CntW  = $clog2(STREAM_SLOTS + 1);
  localparam int unsigned CtxW  = $bits(rmr_pkg::ctx_t);

  // input stage
  logic              s1_valid_q;
  rmr_pkg::in_item_t s1_q;
  logic              s1_adv;
  logic              in_acc;

  // slot state
  logic [STREAM_SLOTS-1:0] started_q, started_d;
  logic [CntW-1:0]         open_q, open_d;

  // context memory and write bypass
  logic              ram_we;
  logic [CtxW-1:0]   ram_rdata;
  rmr_pkg::ctx_t     ctx_rd, ctx_wr;
  logic              byp_valid_q;
  logic [AddrW-1:0]  byp_slot_q;
  rmr_pkg::ctx_t     byp_ctx_q;

  // result stage
  logic               out_valid_q;
  rmr_pkg::out_item_t out_q, out_d;
  logic               res_valid;

  // per-item decode
  logic              slot_ok;
  logic [AddrW-1:0]  slot_idx;
  logic              is_byte, is_abort, is_clear;
  logic              was_started;
  logic              first, last;
  logic [CntW-1:0]   open_mid;
  rmr_pkg::category_e cat;

  // handshake: the input stage moves on whenever the result register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign slot_idx = AddrW'(s1_q.stream_slot);
  assign slot_ok  = (32'(s1_q.stream_slot) < STREAM_SLOTS);
  assign is_byte  = (s1_q.mode == rmr_pkg::MODE_BYTE)  && slot_ok;
  assign is_abort = (s1_q.mode == rmr_pkg::MODE_ABORT) && slot_ok;
  assign is_clear = (s1_q.mode == rmr_pkg::MODE_CLEAR);

  rmr_ram #(
    .Width(CtxW),
    .Depth(STREAM_SLOTS)
  ) u_ctx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_idx),
    .wdata_i(ctx_wr),
    .re_i   (in_acc),
    .raddr_i(AddrW'(in_item_i.stream_slot)),
    .rdata_o(ram_rdata)
  );

  // the write of the previous item lands on the edge this item was read
  assign ctx_rd = (byp_valid_q && (byp_slot_q == slot_idx)) ? byp_ctx_q
                                                           : rmr_pkg::ctx_t'(ram_rdata);
  assign was_started = started_q[slot_idx];

  // context update for a chunk item
  always_comb begin
    ctx_wr = ctx_rd;
    first  = 1'b0;
    if (!was_started) begin
      first            = 1'b1;
      ctx_wr.exp_len   = s1_q.msg_length;
      ctx_wr.rcv_count = '0;
      ctx_wr.stamp     = s1_q.stamp_in;
      ctx_wr.msg_type  = s1_q.type_id;
      ctx_wr.msg_id    = s1_q.msg_stream_in;
    end
    // count saturates at the top of the length range
    if (s1_q.has_byte && (ctx_wr.rcv_count != rmr_pkg::LenMax)) begin
      ctx_wr.rcv_count = ctx_wr.rcv_count + 1'b1;
    end
    last = (s1_q.chunk_end && s1_q.chunk_done) || (ctx_wr.rcv_count >= ctx_wr.exp_len);
  end

  assign ram_we = s1_adv && is_byte;

  // started flags and open message count
  always_comb begin
    started_d = started_q;
    open_d    = open_q;
    open_mid  = open_q + CntW'(first);
    if (is_clear) begin
      started_d = '0;
      open_d    = '0;
    end else if (is_abort) begin
      if (was_started) begin
        started_d[slot_idx] = 1'b0;
        if (open_q != '0) begin
          open_d = open_q - 1'b1;
        end
      end
    end else if (is_byte) begin
      started_d[slot_idx] = !last;
      open_d = open_mid;
      if (last && (open_mid != '0)) begin
        open_d = open_mid - 1'b1;
      end
    end
  end

  // result item; an empty chunk that does not end its message gives none
  assign res_valid = is_byte && (s1_q.has_byte || last);
  assign cat       = rmr_pkg::type_category(ctx_wr.msg_type);

  always_comb begin
    out_d.out_slot       = s1_q.stream_slot;
    out_d.out_byte       = s1_q.has_byte ? s1_q.data_byte : 8'd0;
    out_d.out_has_byte   = s1_q.has_byte;
    out_d.msg_first      = first;
    out_d.msg_last       = last;
    out_d.out_type       = ctx_wr.msg_type;
    out_d.category       = cat;
    out_d.known_type     = (cat != rmr_pkg::CAT_UNKNOWN);
    out_d.out_stamp      = ctx_wr.stamp;
    out_d.out_msg_stream = ctx_wr.msg_id;
    out_d.out_length     = ctx_wr.exp_len;
    out_d.pending_count  = rmr_pkg::PendW'(open_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_valid_q <= 1'b0;
      started_q   <= '0;
      open_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= res_valid;
        started_q   <= started_d;
        open_q      <= open_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // bypass is valid when a write shares the edge of a new read
      if (in_acc) begin
        byp_valid_q <= ram_we;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item_i;
    end
    if (ram_we) begin
      byp_slot_q <= slot_idx;
      byp_ctx_q  <= ctx_wr;
    end
    if (s1_adv && res_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // open count tracks the started flags exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(open_q) == $countones(started_q))
    else $error("open count differs from started flags");

  // an empty result only ever closes a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_has_byte || out_item_o.msg_last))
    else $error("empty result without message end");

  // a finished message leaves its slot idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && last) |=> !started_q[$past(slot_idx)])
    else $error("slot still started after message end");

  // context writes only come from an advancing chunk item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (s1_valid_q && (s1_q.mode == rmr_pkg::MODE_BYTE)))
    else $error("context write without chunk item");

endmodule

FILE: dv/reassembly_checker.sv
// ----------------------------------------------------------------------------
// reassembly_checker
// Watches both channels of the message reassembler, keeps its own copy of
// the per-slot message contexts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module reassembly_checker #(
  parameter int unsigned SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  rmr_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  rmr_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 waiting_o,
  output int                 results_o,
  output int                 msgs_closed_o,
  output int                 peak_open_o
);

  // predicted context of every slot
  bit                        slot_open   [SLOTS];
  logic [rmr_pkg::LenW-1:0]  hdr_len     [SLOTS];
  logic [rmr_pkg::LenW-1:0]  bytes_seen  [SLOTS];
  logic [31:0]               hdr_stamp   [SLOTS];
  logic [7:0]                hdr_type    [SLOTS];
  logic [31:0]               hdr_msg_id  [SLOTS];
  logic [rmr_pkg::PendW-1:0] open_slots;

  rmr_pkg::out_item_t expected_q[$];

  function automatic rmr_pkg::category_e classify_type(input logic [7:0] id);
    case (id)
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6: return rmr_pkg::CAT_CONTROL;
      8'd8:         return rmr_pkg::CAT_AUDIO;
      8'd9:         return rmr_pkg::CAT_VIDEO;
      8'd15, 8'd18: return rmr_pkg::CAT_DATA;
      8'd17, 8'd20: return rmr_pkg::CAT_COMMAND;
      8'd16, 8'd19: return rmr_pkg::CAT_SHARED;
      8'd22:        return rmr_pkg::CAT_AGGR;
      default:      return rmr_pkg::CAT_UNKNOWN;
    endcase
  endfunction

  task automatic advance_context(input rmr_pkg::in_item_t it, output bit emits,
                                 output rmr_pkg::out_item_t res);
    logic [rmr_pkg::SlotW-1:0] s;
    bit                        opened;
    bit                        closes;
    rmr_pkg::category_e        cat;
    s      = it.stream_slot;
    opened = 1'b0;
    emits  = 1'b0;
    res    = '0;
    case (it.mode)
      rmr_pkg::MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_open[i] = 1'b0;
        open_slots = '0;
      end
      rmr_pkg::MODE_ABORT: begin
        if (slot_open[s]) begin
          slot_open[s] = 1'b0;
          if (open_slots != 0) open_slots--;
        end
      end
      rmr_pkg::MODE_BYTE: begin
        if (!slot_open[s]) begin
          slot_open[s]  = 1'b1;
          hdr_len[s]    = it.msg_length;
          hdr_stamp[s]  = it.stamp_in;
          hdr_type[s]   = it.type_id;
          hdr_msg_id[s] = it.msg_stream_in;
          bytes_seen[s] = '0;
          open_slots++;
          opened = 1'b1;
        end
        if (it.has_byte && bytes_seen[s] != rmr_pkg::LenMax) bytes_seen[s]++;
        closes = (it.chunk_end && it.chunk_done) || (bytes_seen[s] >= hdr_len[s]);
        if (closes) begin
          slot_open[s] = 1'b0;
          if (open_slots != 0) open_slots--;
        end
        if (it.has_byte || closes) begin
          cat                = classify_type(hdr_type[s]);
          emits              = 1'b1;
          res.out_slot       = s;
          res.out_byte       = it.has_byte ? it.data_byte : 8'h00;
          res.out_has_byte   = it.has_byte;
          res.msg_first      = opened;
          res.msg_last       = closes;
          res.out_type       = hdr_type[s];
          res.category       = cat;
          res.known_type     = (cat != rmr_pkg::CAT_UNKNOWN);
          res.out_stamp      = hdr_stamp[s];
          res.out_msg_stream = hdr_msg_id[s];
          res.out_length     = hdr_len[s];
          res.pending_count  = open_slots;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit                 emits;
    rmr_pkg::out_item_t res;
    rmr_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_open[i]  = 1'b0;
        hdr_len[i]    = '0;
        bytes_seen[i] = '0;
        hdr_stamp[i]  = '0;
        hdr_type[i]   = '0;
        hdr_msg_id[i] = '0;
      end
      open_slots = '0;
      expected_q.delete();
      fail_count_o  = 0;
      waiting_o     = 0;
      results_o     = 0;
      msgs_closed_o = 0;
      peak_open_o   = 0;
    end else begin
      // predict first: a result never leaves in the cycle its item enters
      if (in_valid_i && in_ready_i) begin
        advance_context(in_item_i, emits, res);
        if (emits) expected_q.push_back(res);
        if (int'(open_slots) > peak_open_o) peak_open_o = open_slots;
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (out_item_i.msg_last === 1'b1) msgs_closed_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item, actual %0h", $time, out_item_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_slot",       want.out_slot,       out_item_i.out_slot);
          check_field("out_byte",       want.out_byte,       out_item_i.out_byte);
          check_field("out_has_byte",   want.out_has_byte,   out_item_i.out_has_byte);
          check_field("msg_first",      want.msg_first,      out_item_i.msg_first);
          check_field("msg_last",       want.msg_last,       out_item_i.msg_last);
          check_field("out_type",       want.out_type,       out_item_i.out_type);
          check_field("category",       want.category,       out_item_i.category);
          check_field("known_type",     want.known_type,     out_item_i.known_type);
          check_field("out_stamp",      want.out_stamp,      out_item_i.out_stamp);
          check_field("out_msg_stream", want.out_msg_stream, out_item_i.out_msg_stream);
          check_field("out_length",     want.out_length,     out_item_i.out_length);
          check_field("pending_count",  want.pending_count,  out_item_i.pending_count);
        end
      end
      waiting_o = expected_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives chunk bytes, aborts and clears into the message reassembler with
// random gaps and back-pressure; a checker beside the block predicts and
// compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SLOTS      = 64;
  localparam int          RAND_ITEMS = 1800;
  localparam int          TAIL_ITEMS = 200;    // final stretch without idling
  localparam int          MAX_CYCLES = 600000;
  localparam int          DRAIN      = 8;      // covers the input and result registers
  localparam logic [1:0]  MODE_UNUSED = 2'd3;  // undefined code, must be ignored

  // standard message type ids, used to bias the type field
  localparam logic [7:0] STD_TYPES [15] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8,
                                            8'd9, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19,
                                            8'd20, 8'd22};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rmr_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rmr_pkg::out_item_t out_item;

  int  fail_count;
  int  waiting;
  int  results;
  int  msgs_closed;
  int  peak_open;
  int  sent      = 0;
  int  cycles    = 0;
  bit  quiet     = 1'b0;   // set for the last part of the run: no idling at all
  bit  gaps_on   = 1'b1;   // toggles to give stretches without source gaps

  initial begin
    forever #6 clk = ~clk;
  end

  rtmp_message_reassembler #(
    .STREAM_SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  reassembly_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .waiting_o    (waiting),
    .results_o    (results),
    .msgs_closed_o(msgs_closed),
    .peak_open_o  (peak_open)
  );

  // assemble one input item
  function automatic rmr_pkg::in_item_t chunk_item(input logic [1:0] md,
                                                   input logic [5:0] slot,
                                                   input logic [23:0] len,
                                                   input logic [7:0] typ,
                                                   input logic has, input logic [7:0] data,
                                                   input logic cend, input logic cdone);
    rmr_pkg::in_item_t it;
    it.mode          = md;
    it.stream_slot   = slot;
    it.msg_length    = len;
    it.stamp_in      = $urandom();
    it.type_id       = typ;
    it.msg_stream_in = $urandom();
    it.has_byte      = has;
    it.data_byte     = data;
    it.chunk_end     = cend;
    it.chunk_done    = cdone;
    return it;
  endfunction

  // send one item; valid is raised without looking at ready and held until taken
  task automatic send_item(input rmr_pkg::in_item_t it);
    if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  // watchdog
  initial begin
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // result side back-pressure: random stall bursts, none in the tail
  initial begin
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    logic [5:0]  work_set [4];
    logic [5:0]  slot;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [1:0]  md;
    logic        cend;
    int          pick;
    int          rand_sent;
    int          fills;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // zero length: first and last on the same item, control type
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd0, 24'd0, 8'd1, 1'b1, 8'h00, 1'b0, 1'b0));
    // one-byte message at the top slot, all-ones header, aggregate type
    begin
      rmr_pkg::in_item_t it;
      it = chunk_item(rmr_pkg::MODE_BYTE, 6'd63, 24'd1, 8'd22, 1'b1, 8'hFF, 1'b1, 1'b1);
      it.stamp_in      = '1;
      it.msg_stream_in = '1;
      send_item(it);
    end
    // empty chunk opens a message silently, later bytes are not first
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd1, 24'd3, 8'd8, 1'b0, 8'h00, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd1, 24'd9, 8'd9, 1'b1, 8'hA5, 1'b0, 1'b0));
    // chunk end without the completion flag does not close
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd1, 24'd9, 8'd9, 1'b1, 8'h5A, 1'b1, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd1, 24'd9, 8'd9, 1'b1, 8'h3C, 1'b0, 1'b0));
    // chunk running past its length: third byte starts the next message
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd2, 24'd2, 8'd9, 1'b1, 8'h11, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd2, 24'd2, 8'd9, 1'b1, 8'h22, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd2, 24'd2, 8'd15, 1'b1, 8'h33, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd2, 24'd2, 8'd15, 1'b1, 8'h44, 1'b1, 1'b0));
    // completion flag closes a message early
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd3, 24'd100, 8'd15, 1'b1, 8'h01, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd3, 24'd100, 8'd15, 1'b1, 8'h02, 1'b1, 1'b1));
    // empty completion gives a result without data
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd4, 24'd50, 8'd17, 1'b1, 8'h80, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd4, 24'd50, 8'd17, 1'b0, 8'hEE, 1'b1, 1'b1));
    // abort of an open slot, abort of an idle slot, then a fresh start
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd5, 24'hFFFFFF, 8'd16, 1'b1, 8'h7F,
                         1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_ABORT, 6'd5, 24'd0, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_ABORT, 6'd5, 24'd0, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd5, 24'd4, 8'd19, 1'b1, 8'h55, 1'b0, 1'b0));
    // clear with several slots open, unknown types
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd6, 24'd10, 8'd255, 1'b1, 8'h66, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd7, 24'd10, 8'd0, 1'b1, 8'h77, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_CLEAR, 6'd0, 24'd0, 8'd0, 1'b0, 8'h00, 1'b0, 1'b0));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd6, 24'd0, 8'd20, 1'b1, 8'h99, 1'b0, 1'b0));
    // the unused code is ignored
    send_item(chunk_item(MODE_UNUSED, 6'd6, 24'd0, 8'd18, 1'b1, 8'hC3, 1'b1, 1'b1));
    send_item(chunk_item(rmr_pkg::MODE_BYTE, 6'd8, 24'd0, 8'd18, 1'b1, 8'hC3, 1'b1, 1'b0));

    // ---- random part ----
    // mostly interleaved messages on a small set of slots with short lengths,
    // plus noise: long or random lengths, aborts, clears, unused codes
    for (int i = 0; i < 4; i++) work_set[i] = 6'($urandom_range(0, SLOTS - 1));
    rand_sent = 0;
    fills     = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (rand_sent >= RAND_ITEMS - TAIL_ITEMS) quiet = 1'b1;
      if ($urandom_range(0, 59) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 39) == 0) begin
        work_set[$urandom_range(0, 3)] = 6'($urandom_range(0, SLOTS - 1));
      end

      // twice in the run: fill every slot so the open count reaches its top
      if ((fills == 0 && rand_sent >= 500) || (fills == 1 && rand_sent >= 1100)) begin
        fills++;
        send_item(chunk_item(rmr_pkg::MODE_CLEAR, 6'd0, 24'd0, 8'd0, 1'b0, 8'h00,
                             1'b0, 1'b0));
        for (int s = 0; s < SLOTS; s++) begin
          len = 24'($urandom_range(1000, 24'hFFFFFF));
          send_item(chunk_item(rmr_pkg::MODE_BYTE, s[5:0], len,
                               STD_TYPES[$urandom_range(0, 14)],
                               1'b1, 8'($urandom()), 1'b0, 1'b0));
        end
        send_item(chunk_item(rmr_pkg::MODE_CLEAR, 6'd0, 24'd0, 8'd0, 1'b0, 8'h00,
                             1'b0, 1'b0));
        rand_sent += SLOTS + 2;
        continue;
      end

      pick = $urandom_range(0, 99);
      if (pick < 2)       md = rmr_pkg::MODE_CLEAR;
      else if (pick < 6)  md = rmr_pkg::MODE_ABORT;
      else if (pick < 7)  md = MODE_UNUSED;
      else                md = rmr_pkg::MODE_BYTE;

      slot = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, SLOTS - 1))
                                         : work_set[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) == 0) len = 24'($urandom());
      else                           len = 24'($urandom_range(0, 15));
      typ  = ($urandom_range(0, 9) < 6) ? STD_TYPES[$urandom_range(0, 14)] : 8'($urandom());
      cend = ($urandom_range(0, 5) == 0);
      send_item(chunk_item(md, slot, len, typ, ($urandom_range(0, 9) != 0), 8'($urandom()),
                           cend, cend ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 1))));
      rand_sent++;
    end
    in_valid <= 1'b0;

    // drain: let the checker see the last accepted item, then wait it out
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d messages closed",
             sent, results, msgs_closed);
    $display("summary: up to %0d slots open at once, %0d mismatches", peak_open, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
